[design/fbm_pkg.sv]
// Shared constants and types for the feather blend block.
// Used by fbm_ram's instances and by feather_blend_fixed_weight_mix.
package fbm_pkg;

	localparam int MAX_IMAGES   = 8;
	localparam int DIST_BITS    = 12;
	localparam int WEIGHT_SHIFT = 16;

	localparam int DIST_IN_W = 12;
	localparam int CHAN_W    = 8;
	localparam int IDX_W     = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
	localparam int CNT_W     = $clog2(MAX_IMAGES + 1);
	localparam int TOT_W     = DIST_BITS + $clog2(MAX_IMAGES);
	localparam int WGT_W     = WEIGHT_SHIFT + 1;
	localparam int PROD_W    = WGT_W + CHAN_W;
	localparam int ACC_W     = PROD_W + $clog2(MAX_IMAGES);
	localparam int STEP_W    = $clog2(WEIGHT_SHIFT + 1);
	localparam int MEM_W     = DIST_BITS + 3 * CHAN_W;

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_FETCH,
		S_DIV,
		S_MUL,
		S_ACC,
		S_OUT
	} fbm_state_t;

endpackage

[design/fbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/feather_blend_fixed_weight_mix.sv]
// Channel   | Direction | Handshake            | Word
// input     | in        | in_valid / in_ready  | distance, blue, green, red, last_source
// output    | out       | out_valid / out_ready| out_blue, out_green, out_red
//
// A source word is taken and written to the source RAM while fewer than MAX_IMAGES
// are held; later words are dropped. The word marked last_source starts the blend:
// each loaded source goes through RAM read, fetch, 17 steps of the restoring weight
// divider, multiply and accumulate; the divider is skipped when the distance sum is
// zero. The output register is then loaded and the FSM goes back to taking words.
// Reset clears the FSM, counts and output valid. The next pixel's words are taken
// while a result waits in the output register; the blend stalls at its end only if
// that register is still full.
// Depends on fbm_pkg and fbm_ram.
module feather_blend_fixed_weight_mix
	import fbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DIST_IN_W-1:0] distance,
	input  logic [CHAN_W-1:0]    blue,
	input  logic [CHAN_W-1:0]    green,
	input  logic [CHAN_W-1:0]    red,
	input  logic                 last_source,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    out_blue,
	output logic [CHAN_W-1:0]    out_green,
	output logic [CHAN_W-1:0]    out_red
);

	function automatic logic [CHAN_W-1:0] sat_chan(input logic [ACC_W-1:0] acc);
		logic [ACC_W-WEIGHT_SHIFT-1:0] v;
		v = acc[ACC_W-1:WEIGHT_SHIFT];
		if (|v[ACC_W-WEIGHT_SHIFT-1:CHAN_W]) begin
			return {CHAN_W{1'b1}};
		end
		return v[CHAN_W-1:0];
	endfunction

	fbm_state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic [TOT_W-1:0]   total_q;
	logic [IDX_W-1:0]   k_q;
	logic [STEP_W-1:0]  step_q;
	logic [TOT_W:0]     rem_q;
	logic [WGT_W-1:0]   quot_q;
	logic [3*CHAN_W-1:0] colour_q;
	logic [PROD_W-1:0]  prod_q [3];
	logic [ACC_W-1:0]   acc_q [3];
	logic               out_valid_q;
	logic [CHAN_W-1:0]  out_b_q, out_g_q, out_r_q;

	logic               in_acc;
	logic               room;
	logic [DIST_BITS-1:0] d_in;
	logic               ram_we, ram_re;
	logic [MEM_W-1:0]   ram_rdata;
	logic               out_free;
	logic               last_k;
	logic               ge;
	logic [TOT_W:0]     rem_sub;
	logic [WGT_W-1:0]   weight;

	assign d_in     = distance[DIST_BITS-1:0];
	assign room     = (count_q < CNT_W'(MAX_IMAGES));
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last_k   = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign ge       = rem_q >= {1'b0, total_q};
	assign rem_sub  = ge ? (rem_q - {1'b0, total_q}) : rem_q;
	assign weight   = quot_q + WGT_W'(1);

	fbm_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_IMAGES)
	) u_src_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({d_in, red, green, blue}),
		.re   (ram_re),
		.raddr(k_q),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_acc && last_source) state_d = S_READ;
			end
			S_READ:  state_d = S_FETCH;
			S_FETCH: state_d = (total_q == '0) ? S_MUL : S_DIV;
			S_DIV: begin
				if (step_q == '0) state_d = S_MUL;
			end
			S_MUL:   state_d = S_ACC;
			S_ACC:   state_d = last_k ? S_OUT : S_READ;
			S_OUT: begin
				if (out_free) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		case (state_q)
			S_LOAD:  in_ready = 1'b1;
			S_READ:  ram_re   = 1'b1;
			default: ;
		endcase
		ram_we = in_acc && room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			total_q     <= '0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) acc_q[c] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (ram_we) begin
						count_q <= count_q + CNT_W'(1);
						total_q <= total_q + TOT_W'(d_in);
					end
					k_q <= '0;
					for (int c = 0; c < 3; c++) acc_q[c] <= '0;
				end
				S_FETCH: begin
					step_q <= STEP_W'(WEIGHT_SHIFT);
				end
				S_DIV: begin
					step_q <= step_q - STEP_W'(1);
				end
				S_ACC: begin
					for (int c = 0; c < 3; c++) acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
					k_q <= k_q + IDX_W'(1);
				end
				S_OUT: begin
					if (out_free) begin
						count_q <= '0;
						total_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: divider, products, output word
	always_ff @(posedge clk) begin
		case (state_q)
			S_FETCH: begin
				rem_q    <= (TOT_W + 1)'(ram_rdata[MEM_W-1:3*CHAN_W]);
				colour_q <= ram_rdata[3*CHAN_W-1:0];
				quot_q   <= '0;
			end
			S_DIV: begin
				// one quotient bit a step; the remainder doubles for the next
				quot_q <= {quot_q[WGT_W-2:0], ge};
				rem_q  <= {rem_sub[TOT_W-1:0], 1'b0};
			end
			S_MUL: begin
				for (int c = 0; c < 3; c++) begin
					prod_q[c] <= PROD_W'(weight) * PROD_W'(colour_q[c*CHAN_W +: CHAN_W]);
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_b_q <= sat_chan(acc_q[0]);
					out_g_q <= sat_chan(acc_q[1]);
					out_r_q <= sat_chan(acc_q[2]);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_blue  = out_b_q;
	assign out_green = out_g_q;
	assign out_red   = out_r_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_IMAGES))
		else $error("source count above buffer depth");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {total_q, 1'b0}))
		else $error("divider remainder out of range");

	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (quot_q <= WGT_W'(1 << WEIGHT_SHIFT)))
		else $error("weight above full scale");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (CNT_W'(k_q) < count_q))
		else $error("source index past loaded count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && !out_ready) |=> (state_q == S_OUT))
		else $error("result loaded over a pending word");

endmodule

[sim/feather_blend_fixed_weight_mix_test.sv]
// Self-checking bench for feather_blend_fixed_weight_mix: drives source words through
// valid/ready, predicts each blended pixel in a scoreboard class and checks every result.
// Depends on fbm_pkg and the block's RTL.
module feather_blend_fixed_weight_mix_test;
	import fbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int IDLE_PERCENT  = 12;
	localparam int RANDOM_WORDS  = 1030;
	localparam int LONG_HOLD     = 300;
	localparam int TAIL_CYCLES   = 200;
	localparam int STALL_LIMIT   = 4000;

	typedef enum int {
		DIST_ZERO,
		DIST_SMALL,
		DIST_FULL,
		DIST_EDGE
	} dist_mode_t;

	typedef struct packed {
		bit [CHAN_W-1:0] blue;
		bit [CHAN_W-1:0] green;
		bit [CHAN_W-1:0] red;
	} blend_pixel_t;

	class pixel_blend_model;
		bit [DIST_BITS-1:0]  seam_dist [MAX_IMAGES];
		bit [3*CHAN_W-1:0]   source_bgr [MAX_IMAGES];
		int unsigned         dist_sum;
		int unsigned         loaded;
		blend_pixel_t        pending_pixels [$];
		int unsigned         errors;

		function new();
			dist_sum = 0;
			loaded = 0;
			errors = 0;
		endfunction

		function bit [CHAN_W-1:0] clamp_channel(longint unsigned acc);
			longint unsigned v;
			v = acc >> WEIGHT_SHIFT;
			return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
		endfunction

		// Load one source word; on the closing word work out the blended pixel.
		function void take_source(bit [DIST_IN_W-1:0] d, bit [CHAN_W-1:0] b,
				bit [CHAN_W-1:0] g, bit [CHAN_W-1:0] r, bit last);
			longint unsigned acc [3];
			longint unsigned wgt;
			blend_pixel_t    px;
			if (loaded < MAX_IMAGES) begin
				seam_dist[loaded] = d[DIST_BITS-1:0];
				source_bgr[loaded] = {r, g, b};
				dist_sum += d[DIST_BITS-1:0];
				loaded++;
			end
			if (!last)
				return;
			for (int c = 0; c < 3; c++)
				acc[c] = 0;
			for (int k = 0; k < loaded; k++) begin
				if (dist_sum == 0)
					wgt = 1;
				else
					wgt = ((longint'(seam_dist[k]) << WEIGHT_SHIFT) / dist_sum) + 1;
				acc[0] += wgt * source_bgr[k][7:0];
				acc[1] += wgt * source_bgr[k][15:8];
				acc[2] += wgt * source_bgr[k][23:16];
			end
			px.blue  = clamp_channel(acc[0]);
			px.green = clamp_channel(acc[1]);
			px.red   = clamp_channel(acc[2]);
			pending_pixels.insert(pending_pixels.size(), px);
			dist_sum = 0;
			loaded = 0;
		endfunction

		function void check_pixel(bit [CHAN_W-1:0] b, bit [CHAN_W-1:0] g,
				bit [CHAN_W-1:0] r);
			blend_pixel_t px;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %0d/%0d/%0d, none pending", $time, b, g, r);
				errors++;
				return;
			end
			px = pending_pixels.pop_front();
			if (b !== px.blue) begin
				$display("%0t: out_blue expected %0d, got %0d", $time, px.blue, b);
				errors++;
			end
			if (g !== px.green) begin
				$display("%0t: out_green expected %0d, got %0d", $time, px.green, g);
				errors++;
			end
			if (r !== px.red) begin
				$display("%0t: out_red expected %0d, got %0d", $time, px.red, r);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_pixels.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [DIST_IN_W-1:0] distance;
	logic [CHAN_W-1:0]    blue;
	logic [CHAN_W-1:0]    green;
	logic [CHAN_W-1:0]    red;
	logic                 last_source;
	logic                 out_valid;
	logic                 out_ready;
	logic [CHAN_W-1:0]    out_blue;
	logic [CHAN_W-1:0]    out_green;
	logic [CHAN_W-1:0]    out_red;

	pixel_blend_model blend_sb = new();
	bit               quiet;
	bit               hold_request;
	int unsigned      stall_cycles;

	feather_blend_fixed_weight_mix u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.distance    (distance),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.last_source (last_source),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			blend_sb.take_source(distance, blue, green, red, last_source);
		if (arst_n && out_valid && out_ready)
			blend_sb.check_pixel(out_blue, out_green, out_red);
	end

	// Give up when neither channel has moved a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(bit [DIST_IN_W-1:0] d, bit [CHAN_W-1:0] b,
			bit [CHAN_W-1:0] g, bit [CHAN_W-1:0] r, bit last);
		if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		distance    <= d;
		blue        <= b;
		green       <= g;
		red         <= r;
		last_source <= last;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic bit [DIST_IN_W-1:0] pick_distance(dist_mode_t mode);
		case (mode)
			DIST_ZERO:  return '0;
			DIST_SMALL: return DIST_IN_W'($urandom_range(15));
			DIST_EDGE: begin
				case ($urandom_range(3))
					0:       return '0;
					1:       return '1;
					2:       return DIST_IN_W'(1);
					default: return DIST_IN_W'(1 << (DIST_IN_W - 1));
				endcase
			end
			default:    return DIST_IN_W'($urandom_range((1 << DIST_IN_W) - 1));
		endcase
	endfunction

	function automatic bit [CHAN_W-1:0] pick_colour(bit extreme);
		if (extreme)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return CHAN_W'($urandom_range(255));
	endfunction

	task automatic send_pixel(int n, dist_mode_t mode, bit extreme, ref int sent);
		for (int k = 0; k < n; k++) begin
			send_word(pick_distance(mode), pick_colour(extreme), pick_colour(extreme),
				pick_colour(extreme), k == n - 1);
			sent++;
		end
	endtask

	// Drop valid so the word already taken is not offered again while waiting.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (blend_sb.waiting() != 0)
			@(negedge clk);
	endtask

	initial begin
		int         sent;
		int         pixel_no;
		int         n;
		dist_mode_t mode;
		int         pick;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		distance     <= '0;
		blue         <= '0;
		green        <= '0;
		red          <= '0;
		last_source  <= 1'b0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		sent         = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Lone source with zero distance: weight 1, everything shifts out to zero.
		send_word('0, 8'h00, 8'h00, 8'h00, 1'b1);
		// Lone source at full distance and full colour: comes out at full scale.
		send_word('1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// Zero distance sum over two sources.
		send_word('0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_word('0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// One source takes nearly all the weight.
		send_word('1, 8'hAA, 8'h55, 8'h0F, 1'b0);
		send_word('0, 8'h55, 8'hAA, 8'hF0, 1'b1);
		// Full set of sources at maximum distance and colour.
		for (int k = 0; k < MAX_IMAGES; k++)
			send_word('1, 8'hFF, 8'hFF, 8'hFF, k == MAX_IMAGES - 1);
		// Overfull pixel: the extra sources must be dropped, the last still closes it.
		for (int k = 0; k < MAX_IMAGES + 2; k++)
			send_word(12'h800 >> k, 8'h01 << (k % 8), 8'h80 >> (k % 8), CHAN_W'(k * 25),
				k == MAX_IMAGES + 1);

		pixel_no = 0;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (pixel_no == 40)
				hold_request = 1'b1;
			if (pixel_no == 90)
				drain_pixels();
			quiet = (pixel_no >= 130 && pixel_no < 170);

			pick = $urandom_range(99);
			if (pick < 8)
				n = $urandom_range(MAX_IMAGES + 1, MAX_IMAGES + 4);
			else
				n = $urandom_range(1, MAX_IMAGES);

			pick = $urandom_range(99);
			if (pick < 10)
				mode = DIST_ZERO;
			else if (pick < 30)
				mode = DIST_SMALL;
			else if (pick < 45)
				mode = DIST_EDGE;
			else
				mode = DIST_FULL;

			send_pixel(n, mode, $urandom_range(99) < 10, sent);
			pixel_no++;
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		drain_pixels();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (blend_sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
design/fbm_pkg.sv
design/fbm_ram.sv
design/feather_blend_fixed_weight_mix.sv
sim/feather_blend_fixed_weight_mix_test.sv
